// ===== hw/rtl/rc4kg_pkg.sv =====
// Shared types, codes and the control program of the RC4 keystream generator.
package rc4kg_pkg;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_SCHED = 2'd1,
    OP_GEN   = 2'd2,
    OP_NONE  = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    CFG_WORD_BITS  = 2'd0,
    CFG_KEY_LENGTH = 2'd1
  } cfg_reg_e;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] key_word;
    logic [7:0] key_index;
  } in_item_t;

  typedef struct packed {
    logic [7:0] keystream_word;
  } out_item_t;

  typedef struct packed {
    logic [1:0] addr;
    logic [8:0] data;
  } cfg_item_t;

  // Permutation read address source
  typedef enum logic [2:0] {
    RD_NONE   = 3'd0,
    RD_I      = 3'd1,
    RD_I_INC  = 3'd2,
    RD_J_NEXT = 3'd3,
    RD_T      = 3'd4
  } rd_sel_e;

  // Permutation write address/data source
  typedef enum logic [1:0] {
    WR_NONE = 2'd0,
    WR_FILL = 2'd1,
    WR_I_RD = 2'd2,
    WR_J_SA = 2'd3
  } wr_sel_e;

  // Next-step selection
  typedef enum logic [2:0] {
    SQ_NEXT     = 3'd0,
    SQ_FETCH    = 3'd1,
    SQ_LOOP     = 3'd2,
    SQ_EMIT     = 3'd3,
    SQ_DISPATCH = 3'd4
  } seq_e;

  typedef logic [3:0] upc_t;

  localparam upc_t UPC_FETCH = 4'd0;
  localparam upc_t UPC_LOAD  = 4'd1;
  localparam upc_t UPC_FILL  = 4'd2;
  localparam upc_t UPC_K0    = 4'd3;
  localparam upc_t UPC_K1    = 4'd4;
  localparam upc_t UPC_K2    = 4'd5;
  localparam upc_t UPC_K3    = 4'd6;
  localparam upc_t UPC_FIN   = 4'd7;
  localparam upc_t UPC_G0    = 4'd8;
  localparam upc_t UPC_G1    = 4'd9;
  localparam upc_t UPC_G2    = 4'd10;
  localparam upc_t UPC_G3    = 4'd11;
  localparam upc_t UPC_G4    = 4'd12;

  typedef struct packed {
    rd_sel_e rd_sel;
    wr_sel_e wr_sel;
    logic    add_key;
    logic    key_rd;
    logic    key_wr;
    logic    inc_i;
    logic    inc_k;
    logic    load_j;
    logic    load_sa;
    logic    load_sb;
    logic    emit;
    logic    finish;
    seq_e    seq;
    upc_t    target;
  } ctrl_t;

  typedef struct packed {
    logic loop_last;
    logic out_full;
    logic scheduled;
  } status_t;

  localparam ctrl_t CTRL_NOP = '{
    rd_sel:  RD_NONE,
    wr_sel:  WR_NONE,
    add_key: 1'b0,
    key_rd:  1'b0,
    key_wr:  1'b0,
    inc_i:   1'b0,
    inc_k:   1'b0,
    load_j:  1'b0,
    load_sa: 1'b0,
    load_sb: 1'b0,
    emit:    1'b0,
    finish:  1'b0,
    seq:     SQ_FETCH,
    target:  UPC_FETCH
  };

  // Control store
  function automatic ctrl_t ucode_rom(input upc_t upc);
    ctrl_t c;
    c = CTRL_NOP;
    case (upc)
      UPC_FETCH: c.seq = SQ_DISPATCH;
      UPC_LOAD: begin
        c.key_wr = 1'b1;
      end
      UPC_FILL: begin
        c.wr_sel = WR_FILL;
        c.inc_i  = 1'b1;
        c.seq    = SQ_LOOP;
        c.target = UPC_FILL;
      end
      UPC_K0: begin
        c.rd_sel = RD_I;
        c.key_rd = 1'b1;
        c.seq    = SQ_NEXT;
      end
      UPC_K1: begin
        c.rd_sel  = RD_J_NEXT;
        c.add_key = 1'b1;
        c.load_j  = 1'b1;
        c.load_sa = 1'b1;
        c.seq     = SQ_NEXT;
      end
      UPC_K2: begin
        c.wr_sel = WR_I_RD;
        c.seq    = SQ_NEXT;
      end
      UPC_K3: begin
        c.wr_sel = WR_J_SA;
        c.inc_i  = 1'b1;
        c.inc_k  = 1'b1;
        c.seq    = SQ_LOOP;
        c.target = UPC_K0;
      end
      UPC_FIN: begin
        c.finish = 1'b1;
      end
      UPC_G0: begin
        c.rd_sel = RD_I_INC;
        c.inc_i  = 1'b1;
        c.seq    = SQ_NEXT;
      end
      UPC_G1: begin
        c.rd_sel  = RD_J_NEXT;
        c.load_j  = 1'b1;
        c.load_sa = 1'b1;
        c.seq     = SQ_NEXT;
      end
      UPC_G2: begin
        c.wr_sel  = WR_I_RD;
        c.load_sb = 1'b1;
        c.seq     = SQ_NEXT;
      end
      UPC_G3: begin
        c.wr_sel = WR_J_SA;
        c.rd_sel = RD_T;
        c.seq    = SQ_NEXT;
      end
      UPC_G4: begin
        c.emit = 1'b1;
        c.seq  = SQ_EMIT;
      end
      default: c = CTRL_NOP;
    endcase
    return c;
  endfunction

endpackage

// ===== hw/rtl/rc4kg_chan_if.sv =====
// Valid/ready channel interface carrying one payload per beat.
interface rc4kg_chan_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/rc4kg_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module rc4kg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read-during-write to the same address returns the old word
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/rc4kg_seq.sv =====
// Micro-sequencer: step counter, control store lookup and opcode dispatch.
module rc4kg_seq (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic [1:0]         in_opcode_i,
  input  rc4kg_pkg::status_t status_i,
  output rc4kg_pkg::ctrl_t   ctrl_o,
  output logic               in_ready_o
);
  import rc4kg_pkg::*;

  upc_t  upc_q, upc_d;
  ctrl_t rom_word;

  assign rom_word   = ucode_rom(upc_q);
  assign in_ready_o = (rom_word.seq == SQ_DISPATCH);

  always_comb begin
    ctrl_o = rom_word;
    // hold the emit step while the output register is occupied
    if (rom_word.seq == SQ_EMIT && status_i.out_full) begin
      ctrl_o.emit = 1'b0;
    end
  end

  always_comb begin
    upc_d = upc_q;
    case (rom_word.seq)
      SQ_DISPATCH: begin
        if (in_valid_i) begin
          case (opcode_e'(in_opcode_i))
            OP_LOAD:  upc_d = UPC_LOAD;
            OP_SCHED: upc_d = UPC_FILL;
            OP_GEN:   upc_d = status_i.scheduled ? UPC_G0 : UPC_FETCH;
            default:  upc_d = UPC_FETCH;
          endcase
        end
      end
      SQ_NEXT:  upc_d = upc_q + 4'd1;
      SQ_FETCH: upc_d = UPC_FETCH;
      SQ_LOOP:  upc_d = status_i.loop_last ? upc_q + 4'd1 : rom_word.target;
      SQ_EMIT:  upc_d = status_i.out_full ? upc_q : UPC_FETCH;
      default:  upc_d = UPC_FETCH;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= UPC_FETCH;
    end else begin
      upc_q <= upc_d;
    end
  end

endmodule

// ===== hw/rtl/rc4kg_dp.sv =====
// Datapath: indices, swap registers, permutation and key stores, output register.
module rc4kg_dp #(
  parameter int MAX_WORD_BITS = 8,
  parameter int KEY_DEPTH     = 256
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rc4kg_pkg::ctrl_t    ctrl_i,
  input  logic                accept_i,
  input  rc4kg_pkg::in_item_t item_i,
  input  logic [3:0]          word_bits_i,
  input  logic [8:0]          key_length_i,
  input  logic                out_ready_i,
  output rc4kg_pkg::status_t  status_o,
  output logic                out_valid_o,
  output logic [7:0]          out_word_o
);
  import rc4kg_pkg::*;

  localparam int W   = MAX_WORD_BITS;
  localparam int PD  = 1 << W;
  localparam int KAW = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
  localparam logic [W-1:0] WONE = W'(1);

  logic [W-1:0]   i_q, j_q, sa_q, sb_q;
  logic [KAW-1:0] k_q;
  logic           sched_q;
  logic [W-1:0]   kw_q;
  logic [7:0]     kidx_q;
  logic           out_valid_q;
  logic [W-1:0]   out_q;
  logic           fwd_hit_q;
  logic [W-1:0]   fwd_data_q;

  logic [3:0]     eff_bits;
  logic [W-1:0]   mask;
  logic [8:0]     eff_klen;
  logic           k_last;

  logic           p_we, p_re;
  logic [W-1:0]   p_waddr, p_wdata, p_raddr, p_rdata, prd;
  logic [W-1:0]   j_next, key_term;
  logic           k_we;
  logic [W-1:0]   k_rdata;

  // word size clamped to 1..MAX_WORD_BITS
  always_comb begin
    if (word_bits_i == 4'd0) begin
      eff_bits = 4'd1;
    end else if (word_bits_i > 4'(W)) begin
      eff_bits = 4'(W);
    end else begin
      eff_bits = word_bits_i;
    end
    for (int n = 0; n < W; n++) begin
      mask[n] = (4'(n) < eff_bits);
    end
  end

  // key length clamped to 1..KEY_DEPTH
  always_comb begin
    if (key_length_i == 9'd0) begin
      eff_klen = 9'd1;
    end else if (key_length_i > 9'(KEY_DEPTH)) begin
      eff_klen = 9'(KEY_DEPTH);
    end else begin
      eff_klen = key_length_i;
    end
  end

  assign k_last = (9'(k_q) == eff_klen - 9'd1);

  // read data with forwarding of a same-cycle write to the read address
  assign prd      = fwd_hit_q ? fwd_data_q : p_rdata;
  assign key_term = ctrl_i.add_key ? (k_rdata & mask) : '0;
  assign j_next   = (j_q + (prd & mask) + key_term) & mask;

  always_comb begin
    p_re    = (ctrl_i.rd_sel != RD_NONE);
    case (ctrl_i.rd_sel)
      RD_I:      p_raddr = i_q;
      RD_I_INC:  p_raddr = (i_q + WONE) & mask;
      RD_J_NEXT: p_raddr = j_next;
      RD_T:      p_raddr = (sa_q + sb_q) & mask;
      default:   p_raddr = i_q;
    endcase
  end

  always_comb begin
    p_we = 1'b1;
    case (ctrl_i.wr_sel)
      WR_FILL: begin
        p_waddr = i_q;
        p_wdata = i_q;
      end
      WR_I_RD: begin
        p_waddr = i_q;
        p_wdata = prd;
      end
      WR_J_SA: begin
        p_waddr = j_q;
        p_wdata = sa_q;
      end
      default: begin
        p_we    = 1'b0;
        p_waddr = i_q;
        p_wdata = prd;
      end
    endcase
  end

  rc4kg_ram #(.WIDTH(W), .DEPTH(PD)) u_perm_ram (
    .clk_i   (clk_i),
    .we_i    (p_we),
    .waddr_i (p_waddr),
    .wdata_i (p_wdata),
    .re_i    (p_re),
    .raddr_i (p_raddr),
    .rdata_o (p_rdata)
  );

  assign k_we = ctrl_i.key_wr && ({1'b0, kidx_q} < 9'(KEY_DEPTH));

  rc4kg_ram #(.WIDTH(W), .DEPTH(KEY_DEPTH)) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (k_we),
    .waddr_i (kidx_q[KAW-1:0]),
    .wdata_i (kw_q),
    .re_i    (ctrl_i.key_rd),
    .raddr_i (k_q),
    .rdata_o (k_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      i_q         <= '0;
      j_q         <= '0;
      k_q         <= '0;
      sched_q     <= 1'b0;
      out_valid_q <= 1'b0;
      fwd_hit_q   <= 1'b0;
    end else begin
      if (accept_i && item_i.opcode == OP_SCHED) begin
        i_q <= '0;
        j_q <= '0;
        k_q <= '0;
      end else begin
        if (ctrl_i.inc_i) begin
          i_q <= (i_q + WONE) & mask;
        end
        if (ctrl_i.finish) begin
          j_q <= '0;
        end else if (ctrl_i.load_j) begin
          j_q <= j_next;
        end
        if (ctrl_i.inc_k) begin
          k_q <= k_last ? '0 : k_q + KAW'(1);
        end
      end
      if (ctrl_i.finish) begin
        sched_q <= 1'b1;
      end
      if (p_re) begin
        fwd_hit_q <= p_we && (p_waddr == p_raddr);
      end
      if (ctrl_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      kw_q   <= item_i.key_word[W-1:0];
      kidx_q <= item_i.key_index;
    end
    if (p_re) begin
      fwd_data_q <= p_wdata;
    end
    if (ctrl_i.load_sa) begin
      sa_q <= prd;
    end
    if (ctrl_i.load_sb) begin
      sb_q <= prd;
    end
    if (ctrl_i.emit) begin
      out_q <= prd & mask;
    end
  end

  assign status_o.loop_last = (i_q == mask);
  assign status_o.out_full  = out_valid_q;
  assign status_o.scheduled = sched_q;
  assign out_valid_o        = out_valid_q;
  assign out_word_o         = 8'(out_q);

endmodule

// ===== hw/rtl/rc4_keystream_generator.sv =====
// Top level of the generalised RC4 keystream generator.
//
// Channels: in_i takes one command beat (load key word, run key schedule or
// generate); out_o returns one keystream word per generate beat; cfg_i writes
// word_bits (index 0) and key_length (index 1) and is always ready.
// A small micro-sequencer steps through a control store that drives one
// permutation RAM (one write and one registered read a cycle) and a key RAM.
// Steps per beat, counted from acceptance to the next beat accepted:
//   load          one key store write step (LOAD)
//   schedule      a fill sweep over the 2^N entries (N = effective word_bits),
//                 then the swap loop steps K0..K3 for each entry and a finish step
//   generate      steps G0..G4; the last step registers the word into the
//                 output register. The four permutation accesses of the
//                 swap plus the final lookup share the single read port.
//   generate before any schedule, and the unused opcode: no beat out
// The output register holds a finished word while the next command is taken;
// a stalled receiver only holds the sequencer when a second word is ready.
// Reset clears the indices and the scheduled flag and restores word_bits 8
// and key_length 16; the RAM contents are left as they are (no clearing pass).
module rc4_keystream_generator #(
  parameter int MAX_WORD_BITS = 8,
  parameter int KEY_DEPTH     = 256
) (
  input logic          clk_i,
  input logic          rst_ni,
  rc4kg_chan_if.sink   in_i,
  rc4kg_chan_if.source out_o,
  rc4kg_chan_if.sink   cfg_i
);
  import rc4kg_pkg::*;

  logic [3:0] word_bits_q;
  logic [8:0] key_length_q;
  ctrl_t      ctrl;
  status_t    status;
  logic       in_accept;
  in_item_t   in_item;
  logic [7:0] out_word;

  // configuration registers; writes are to be made only while the block is idle (not enforced here)
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_bits_q  <= 4'd8;
      key_length_q <= 9'd16;
    end else if (cfg_i.valid) begin
      case (cfg_reg_e'(cfg_i.payload.addr))
        CFG_WORD_BITS:  word_bits_q  <= cfg_i.payload.data[3:0];
        CFG_KEY_LENGTH: key_length_q <= cfg_i.payload.data;
        default: ;
      endcase
    end
  end

  assign in_item.opcode    = in_i.payload.opcode;
  assign in_item.key_word  = in_i.payload.key_word;
  assign in_item.key_index = in_i.payload.key_index;
  assign in_accept         = in_i.valid && in_i.ready;

  rc4kg_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_opcode_i (in_i.payload.opcode),
    .status_i    (status),
    .ctrl_o      (ctrl),
    .in_ready_o  (in_i.ready)
  );

  rc4kg_dp #(
    .MAX_WORD_BITS (MAX_WORD_BITS),
    .KEY_DEPTH     (KEY_DEPTH)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (ctrl),
    .accept_i     (in_accept),
    .item_i       (in_item),
    .word_bits_i  (word_bits_q),
    .key_length_i (key_length_q),
    .out_ready_i  (out_o.ready),
    .status_o     (status),
    .out_valid_o  (out_o.valid),
    .out_word_o   (out_word)
  );

  assign out_o.payload.keystream_word = out_word;

  // a word is never written over one still waiting at the output
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.emit |-> !status.out_full)
    else $error("keystream word emitted while output register full");

  // generate before scheduling is dropped and the sequencer is free again
  a_gen_unscheduled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && in_i.payload.opcode == OP_GEN && !status.scheduled)
      |=> in_i.ready)
    else $error("unscheduled generate did not return to fetch");

  // an output beat only appears after an emit step
  a_out_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_o.valid) |-> $past(ctrl.emit))
    else $error("output valid without emit step");

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the RC4 keystream generator: random valid/ready traffic, shadow cipher.
module tb_top;
  import rc4kg_pkg::*;

  localparam int MAX_WORD_BITS = 8;
  localparam int KEY_DEPTH     = 256;
  // Longest command is a full-width key schedule; quiet time before touching registers
  localparam int SETTLE_CYCLES = 5 * (1 << MAX_WORD_BITS) + 18;
  localparam int HOLD_CYCLES   = 400;
  localparam int DRAIN_LIMIT   = 20000;
  // Unmapped register indices, written to show they are harmless
  localparam bit [1:0] CFG_SPARE_A = 2'd2;
  localparam bit [1:0] CFG_SPARE_B = 2'd3;

  // Shadow copy of the cipher state plus the words still owed by the block.
  class keystream_ledger;
    bit [7:0] sbox [KEY_DEPTH];
    bit [7:0] key_mem [KEY_DEPTH];
    bit [7:0] ptr_i;
    bit [7:0] ptr_j;
    bit       keyed;
    bit [3:0] word_bits;
    bit [8:0] key_length;
    bit [7:0] words_due [$];
    int       mismatches;

    function new();
      word_bits  = 4'd8;
      key_length = 9'd16;
      ptr_i      = '0;
      ptr_j      = '0;
      keyed      = 1'b0;
      mismatches = 0;
    endfunction

    // Out-of-range register values saturate
    function int unsigned width_in_force();
      if (word_bits == 0) return 1;
      if (word_bits > MAX_WORD_BITS) return MAX_WORD_BITS;
      return word_bits;
    endfunction

    function int unsigned keys_in_force();
      if (key_length == 0) return 1;
      if (key_length > KEY_DEPTH) return KEY_DEPTH;
      return key_length;
    endfunction

    function bit [7:0] word_mask();
      return 8'((1 << width_in_force()) - 1);
    endfunction

    function void apply_reg(cfg_item_t c);
      case (c.addr)
        CFG_WORD_BITS:  word_bits  = c.data[3:0];
        CFG_KEY_LENGTH: key_length = c.data;
        default: ;
      endcase
    endfunction

    // Identity fill then the swap walk; key words masked to the width in force now
    function void key_schedule();
      bit [7:0]    mask;
      bit [7:0]    j;
      bit [7:0]    tmp;
      int unsigned span;
      int unsigned klen;
      int unsigned n;
      mask = word_mask();
      span = 1 << width_in_force();
      klen = keys_in_force();
      for (n = 0; n < span; n++) sbox[n] = 8'(n);
      j = '0;
      for (n = 0; n < span; n++) begin
        j = (j + sbox[n] + (key_mem[n % klen] & mask)) & mask;
        tmp     = sbox[n];
        sbox[n] = sbox[j];
        sbox[j] = tmp;
      end
      ptr_i = '0;
      ptr_j = '0;
      keyed = 1'b1;
    endfunction

    // One PRGA step at the current width
    function bit [7:0] next_word();
      bit [7:0] mask;
      bit [7:0] a;
      bit [7:0] b;
      bit [7:0] t;
      bit [7:0] tmp;
      mask    = word_mask();
      a       = (ptr_i + 8'd1) & mask;
      b       = (ptr_j + (sbox[a] & mask)) & mask;
      tmp     = sbox[a];
      sbox[a] = sbox[b];
      sbox[b] = tmp;
      ptr_i   = a;
      ptr_j   = b;
      t       = (sbox[a] + sbox[b]) & mask;
      return sbox[t] & mask;
    endfunction

    function void note_command(in_item_t cmd);
      case (cmd.opcode)
        OP_LOAD:  key_mem[cmd.key_index] = cmd.key_word;
        OP_SCHED: key_schedule();
        OP_GEN:   if (keyed) words_due.push_back(next_word());
        default: ;
      endcase
    endfunction

    task report_mismatch(string what);
      mismatches++;
      if (mismatches <= 100) $display("MISMATCH @%0t: %s", $time, what);
    endtask

    task check_word(out_item_t got);
      out_item_t want;
      if (words_due.size() == 0) begin
        report_mismatch($sformatf("keystream word %02h with nothing outstanding",
                                  got.keystream_word));
      end else begin
        want.keystream_word = words_due.pop_front();
        if (got.keystream_word !== want.keystream_word)
          report_mismatch($sformatf("keystream_word got %02h want %02h",
                                    got.keystream_word, want.keystream_word));
      end
    endtask

    function int outstanding();
      return words_due.size();
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  rc4kg_chan_if #(.payload_t(in_item_t))  in_ch ();
  rc4kg_chan_if #(.payload_t(out_item_t)) out_ch ();
  rc4kg_chan_if #(.payload_t(cfg_item_t)) cfg_ch ();

  rc4_keystream_generator dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch),
    .cfg_i  (cfg_ch)
  );

  keystream_ledger ledger = new();

  bit          key_loaded [KEY_DEPTH];  // key store entries written since reset
  bit          calm;                    // final stretch: no idling on either side
  bit          hold_req;                // asks the receiver for one long hold-off
  int unsigned issued;                  // command beats offered that the block acts on

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Single reset at start of run
  initial begin
    rst_ni = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Monitors sample at the edge, so every beat is seen with its pre-edge values.
  // Config first so a register write lands before any later command is scored.
  always @(posedge clk_i) begin
    if (rst_ni && cfg_ch.valid && cfg_ch.ready) ledger.apply_reg(cfg_ch.payload);
  end

  always @(posedge clk_i) begin
    if (rst_ni && in_ch.valid && in_ch.ready) ledger.note_command(in_ch.payload);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) ledger.check_word(out_ch.payload);
  end

  // Receiver: random ready bursts, one long hold-off on request, always ready when calm
  initial begin : receiver
    out_ch.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else if (calm) begin
        out_ch.ready <= 1'b1;
        @(posedge clk_i);
      end else begin
        out_ch.ready <= ($urandom_range(0, 2) != 0);
        repeat ($urandom_range(1, 17)) @(posedge clk_i);
      end
    end
  end

  // Key words a schedule will read: min(key length, table size), from index 0
  function automatic int unsigned key_span();
    int unsigned span;
    span = 1 << ledger.width_in_force();
    return (ledger.keys_in_force() < span) ? ledger.keys_in_force() : span;
  endfunction

  // Offer one command beat and hold it until taken. valid is only dropped
  // ahead of an idle burst, never in the step where the next beat goes up.
  task automatic send_cmd(opcode_e op, bit [7:0] kw, bit [7:0] ki);
    in_item_t cmd;
    cmd.opcode    = op;
    cmd.key_word  = kw;
    cmd.key_index = ki;
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
    in_ch.payload <= cmd;
    in_ch.valid   <= 1'b1;
    do @(posedge clk_i); while (!in_ch.ready);
    if (op == OP_LOAD) key_loaded[ki] = 1'b1;
    if (op != OP_NONE) issued++;
  endtask

  task automatic gen_words(int unsigned count);
    repeat (count) send_cmd(OP_GEN, 8'($urandom), 8'($urandom));
  endtask

  // Schedule, first filling any key store entry the walk would read unwritten
  task automatic rekey();
    int unsigned k;
    for (k = 0; k < key_span(); k++)
      if (!key_loaded[k]) send_cmd(OP_LOAD, 8'($urandom), 8'(k));
    send_cmd(OP_SCHED, 8'($urandom), 8'($urandom));
  endtask

  // Stop offering, wait for every owed word, then sit out the given latency
  task automatic await_results(int unsigned settle);
    int unsigned guard;
    in_ch.valid <= 1'b0;
    guard = 0;
    do begin
      @(posedge clk_i);
      guard++;
    end while (ledger.outstanding() != 0 && guard < DRAIN_LIMIT);
    repeat (settle) @(posedge clk_i);
  endtask

  task automatic poke_reg(bit [1:0] addr, bit [8:0] data);
    cfg_ch.payload <= cfg_item_t'{addr: addr, data: data};
    cfg_ch.valid   <= 1'b1;
    do @(posedge clk_i); while (!cfg_ch.ready);
  endtask

  // Registers only change with the block idle; upper data bits of word_bits are junk
  task automatic retune(bit [3:0] wb, bit [8:0] kl);
    await_results(SETTLE_CYCLES);
    poke_reg(CFG_WORD_BITS, {5'($urandom), wb});
    poke_reg(CFG_KEY_LENGTH, kl);
    poke_reg(($urandom_range(0, 1) != 0) ? CFG_SPARE_A : CFG_SPARE_B, 9'($urandom));
    cfg_ch.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // Mostly well-formed key/schedule/generate runs with random content, some noise
  task automatic run_phase(int unsigned quota);
    int unsigned stop;
    int unsigned pick;
    opcode_e     op;
    stop = issued + quota;
    // keep the previous stream going first: covers a word size change after keying
    gen_words($urandom_range(2, 5));
    while (issued < stop) begin
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        repeat ($urandom_range(0, 4))
          send_cmd(OP_LOAD, 8'($urandom), 8'($urandom_range(0, key_span() - 1)));
        rekey();
        gen_words($urandom_range(1, 12));
      end else if (pick < 85) begin
        gen_words($urandom_range(1, 8));
      end else begin
        op = opcode_e'($urandom_range(0, 3));
        if (op == OP_SCHED) rekey();
        else send_cmd(op, 8'($urandom), 8'($urandom));
      end
    end
  endtask

  initial begin : stimulus
    int unsigned k;
    in_ch.valid    <= 1'b0;
    in_ch.payload  <= '0;
    cfg_ch.valid   <= 1'b0;
    cfg_ch.payload <= '0;
    calm     = 1'b0;
    hold_req = 1'b0;
    issued   = 0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);

    // Directed: generate before any schedule and the unused opcode give nothing
    send_cmd(OP_GEN, 8'hFF, 8'hFF);
    send_cmd(OP_NONE, 8'hFF, 8'hFF);
    // Reset key length is 16; the first schedule runs at full width so that
    // every table entry is defined for any later width
    for (k = 0; k < 16; k++) send_cmd(OP_LOAD, 8'(k * 8'h3B), 8'(k));
    send_cmd(OP_LOAD, 8'hFF, 8'hFF);
    send_cmd(OP_SCHED, 8'h00, 8'h00);
    gen_words(5);
    run_phase(45);

    // Narrowest words; zero values saturate to one
    retune(4'd1, 9'd1);
    run_phase(55);
    retune(4'd0, 9'd0);
    run_phase(55);

    // Long receiver hold-off while commands keep coming, then a full drain
    retune(4'd2, 9'd3);
    rekey();
    hold_req = 1'b1;
    gen_words(24);
    await_results(0);
    run_phase(55);

    // Key length beyond the store saturates
    retune(4'd3, 9'd511);
    run_phase(55);
    retune(4'd4, 9'd5);
    run_phase(55);
    // Oversized word width acts as eight; full key store in use
    retune(4'd15, 9'd256);
    run_phase(55);
    retune(4'd5, 9'd33);
    run_phase(55);
    retune(4'd6, 9'd2);
    run_phase(55);
    retune(4'd7, 9'd100);
    run_phase(55);
    retune(4'd9, 9'd7);
    run_phase(55);
    retune(4'd2, 9'd256);
    run_phase(55);

    // Closing stretch at full throughput
    retune(4'd4, 9'd16);
    calm = 1'b1;
    run_phase(55);

    await_results(SETTLE_CYCLES);
    if (ledger.outstanding() != 0)
      ledger.report_mismatch($sformatf("%0d keystream words never arrived",
                                       ledger.outstanding()));
    if (ledger.mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog, well beyond the slowest legal run
  initial begin : watchdog
    #16_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/rc4kg_pkg.sv
hw/rtl/rc4kg_chan_if.sv
hw/rtl/rc4kg_ram.sv
hw/rtl/rc4kg_seq.sv
hw/rtl/rc4kg_dp.sv
hw/rtl/rc4_keystream_generator.sv
tb/sv/tb_top.sv
